>>> design/vgs_pkg.sv
package vgs_pkg;

  localparam int GRID_DIM  = 32;
  localparam int CRD_W     = $clog2(GRID_DIM);
  localparam int VEL_W     = 16;
  localparam int FRAC_BITS = 12;
  localparam int POS_W     = 24;
  localparam int INV_W     = 16;
  localparam int USED_W    = 6;
  localparam int CELL_W    = 3 * CRD_W;
  localparam int BANK_AW   = 3 * (CRD_W - 1);
  localparam int NBANK     = 8;
  localparam int ENTRY_W   = 3 * VEL_W + 1;
  localparam int PROD_W    = POS_W + INV_W + 1;
  localparam int C_W       = PROD_W - FRAC_BITS;
  localparam int B_W       = C_W - FRAC_BITS;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } vgs_op_t;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_INV    = 3'd1,
    CFG_X_USED = 3'd2,
    CFG_Y_USED = 3'd3,
    CFG_Z_USED = 3'd4
  } vgs_cfg_idx_t;

  typedef struct packed {
    logic              mode;
    logic [INV_W-1:0]  inv;
    logic [USED_W-1:0] ux;
    logic [USED_W-1:0] uy;
    logic [USED_W-1:0] uz;
  } vgs_cfg_t;

  // one memory access: either a write of one cell or eight neighbour reads
  typedef struct packed {
    logic                             vld;
    logic                             wr;
    logic [2:0]                       wbank;
    logic [BANK_AW-1:0]               waddr;
    logic [ENTRY_W-1:0]               wdata;
    logic [NBANK-1:0]                 bvld;
    logic [NBANK-1:0][BANK_AW-1:0]    raddr;
    logic [2:0]                       par;
    logic [2:0][FRAC_BITS-1:0]        t;
  } vgs_acc_t;

endpackage

>>> design/vgs_coord.sv
module vgs_coord import vgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  vgs_cfg_t              cfg,
  input  logic                  vld_i,
  input  logic                  op_i,
  input  logic [CELL_W-1:0]     cell_i,
  input  logic [ENTRY_W-1:0]    wdata_i,
  input  logic [2:0][POS_W-1:0] pos_i,
  output vgs_acc_t              acc_o
);

  logic                  s1_vld_r, s2_vld_r;
  logic                  s1_op_r, s2_op_r;
  logic [CELL_W-1:0]     s1_cell_r, s2_cell_r;
  logic [ENTRY_W-1:0]    s1_wdata_r, s2_wdata_r;
  logic [2:0][POS_W-1:0] s1_pos_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic                  acc_vld_r;
  vgs_acc_t acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      acc_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= vld_i;
      s2_vld_r  <= s1_vld_r;
      acc_vld_r <= acc_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r    <= op_i;
      s1_cell_r  <= cell_i;
      s1_wdata_r <= wdata_i;
      s1_pos_r   <= pos_i;
      s2_op_r    <= s1_op_r;
      s2_cell_r  <= s1_cell_r;
      s2_wdata_r <= s1_wdata_r;
      for (int a = 0; a < 3; a++) begin
        prod_r[a] <= $signed(s1_pos_r[a]) * $signed({1'b0, cfg.inv});
      end
      acc_r <= acc_nxt;
    end
  end

  logic signed [PROD_W-1:0] csh;
  logic signed [C_W-1:0]    c;
  logic signed [C_W-1:0]    bsh;
  logic signed [B_W:0]      b0 [3];
  logic signed [B_W:0]      b1 [3];
  logic [2:0]               v0, v1;
  logic [USED_W-1:0]        used [3];
  logic [USED_W-1:0]        used_raw [3];
  logic                     sel, ok;
  logic [CRD_W-1:0]         crd;

  always_comb begin
    used_raw[0] = cfg.ux;
    used_raw[1] = cfg.uy;
    used_raw[2] = cfg.uz;
    acc_nxt = '0;
    acc_nxt.vld   = s2_vld_r;
    acc_nxt.wr    = (s2_op_r == OP_WRITE);
    acc_nxt.wbank = {s2_cell_r[2*CRD_W], s2_cell_r[CRD_W], s2_cell_r[0]};
    acc_nxt.waddr = {s2_cell_r[3*CRD_W-1:2*CRD_W+1], s2_cell_r[2*CRD_W-1:CRD_W+1],
                     s2_cell_r[CRD_W-1:1]};
    acc_nxt.wdata = s2_wdata_r;
    for (int a = 0; a < 3; a++) begin
      // clamp used count to the grid size
      used[a] = (used_raw[a] > USED_W'(GRID_DIM)) ? USED_W'(GRID_DIM) : used_raw[a];
      csh = prod_r[a] >>> FRAC_BITS;
      c = csh[C_W-1:0] - (cfg.mode ? C_W'(1 << (FRAC_BITS - 1)) : C_W'(0));
      bsh = c >>> FRAC_BITS;
      b0[a] = {bsh[B_W-1], bsh[B_W-1:0]};
      b1[a] = b0[a] + (B_W+1)'(1);
      v0[a] = !b0[a][B_W] && (b0[a][B_W-1:0] < B_W'(used[a]));
      v1[a] = !b1[a][B_W] && (b1[a][B_W-1:0] < B_W'(used[a]));
      acc_nxt.par[a] = b0[a][0];
      // nearest mode blends with zero weight, leaving the base corner
      acc_nxt.t[a] = cfg.mode ? c[FRAC_BITS-1:0] : '0;
    end
    for (int p = 0; p < NBANK; p++) begin
      acc_nxt.bvld[p] = 1'b1;
      for (int a = 0; a < 3; a++) begin
        sel = (b0[a][0] != p[a]);
        crd = sel ? b1[a][CRD_W-1:0] : b0[a][CRD_W-1:0];
        ok  = sel ? (v1[a] && cfg.mode) : v0[a];
        acc_nxt.bvld[p] = acc_nxt.bvld[p] && ok;
        acc_nxt.raddr[p][a*(CRD_W-1) +: (CRD_W-1)] = crd[CRD_W-1:1];
      end
    end
  end

  always_comb begin
    acc_o     = acc_r;
    acc_o.vld = acc_vld_r;
  end

endmodule

>>> design/vgs_grid_mem.sv
module vgs_grid_mem import vgs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  vgs_acc_t           acc,
  output logic [ENTRY_W-1:0] rdata_o [NBANK]
);

  localparam int DEPTH = 1 << BANK_AW;

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_r;
    logic               we;

    assign we = en && acc.vld && acc.wr && (acc.wbank == 3'(b));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[acc.waddr] <= acc.wdata;
      end
      if (en) begin
        rdata_r <= mem[acc.raddr[b]];
      end
    end

    assign rdata_o[b] = rdata_r;
  end

endmodule

>>> design/vgs_lerp.sv
module vgs_lerp import vgs_pkg::*; #(
  parameter int LANES = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic [FRAC_BITS-1:0]    t_i,
  input  logic signed [VEL_W-1:0] a_i [LANES],
  input  logic signed [VEL_W-1:0] b_i [LANES],
  output logic                    vld_o,
  output logic signed [VEL_W-1:0] y_o [LANES]
);

  localparam int DW = VEL_W + 1;
  localparam int PW = DW + FRAC_BITS + 1;

  logic                    vld1_r, vld2_r;
  logic signed [PW-1:0]    prod_r [LANES];
  logic signed [VEL_W-1:0] a1_r [LANES];
  logic signed [VEL_W-1:0] y_r [LANES];
  logic signed [DW-1:0]    diff [LANES];
  logic signed [PW-1:0]    sh [LANES];
  logic signed [PW-1:0]    sum [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      diff[l] = {b_i[l][VEL_W-1], b_i[l]} - {a_i[l][VEL_W-1], a_i[l]};
      sh[l]   = prod_r[l] >>> FRAC_BITS;
      sum[l]  = PW'(a1_r[l]) + sh[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        prod_r[l] <= diff[l] * $signed({1'b0, t_i});
        a1_r[l]   <= a_i[l];
        y_r[l]    <= sum[l][VEL_W-1:0];
      end
    end
  end

  assign vld_o = vld2_r;
  assign y_o   = y_r;

endmodule

>>> design/velocity_grid_sampler.sv
// Velocity grid sampler: a 32x32x32 grid of 16-bit velocity vectors with a
// solid flag per cell, stored in eight banks split by coordinate parity so all
// eight neighbours of a sample are read in the same cycle. in_tuser is the op
// (0 write a cell, 1 sample). Writes take one transfer and give no result; a
// sample gives one result. One item is taken every cycle: the pipeline (three
// coordinate stages, the bank read, corner select and three two-stage lerp
// steps) freezes as a whole only while a result waits on out_tready. Writes
// land at the bank read stage in order with samples. Cells read before being
// written give undefined values. Configuration writes are taken at any time
// on the cfg channel and must only be issued while the block is idle.
module velocity_grid_sampler import vgs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cell_index, write_vel_x, write_vel_y, write_vel_z, write_solid,
  // pos_x, pos_y, pos_z
  input  logic [135:0] in_tdata,
  // op
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vel_x, vel_y, vel_z
  output logic [47:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  vgs_cfg_t cfg_r;
  logic     en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= 1'b1;
      cfg_r.inv  <= INV_W'(4096);
      cfg_r.ux   <= USED_W'(32);
      cfg_r.uy   <= USED_W'(32);
      cfg_r.uz   <= USED_W'(32);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:   cfg_r.mode <= cfg_data[0];
        CFG_INV:    cfg_r.inv  <= cfg_data[INV_W-1:0];
        CFG_X_USED: cfg_r.ux   <= cfg_data[USED_W-1:0];
        CFG_Y_USED: cfg_r.uy   <= cfg_data[USED_W-1:0];
        CFG_Z_USED: cfg_r.uz   <= cfg_data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the whole pipeline while a result waits
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [2:0][POS_W-1:0] pos;
  vgs_acc_t              acc;

  assign pos[0] = in_tdata[87:64];
  assign pos[1] = in_tdata[111:88];
  assign pos[2] = in_tdata[135:112];

  vgs_coord u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .vld_i   (in_tvalid),
    .op_i    (in_tuser[0]),
    .cell_i  (in_tdata[14:0]),
    .wdata_i ({in_tdata[63], in_tdata[62:47], in_tdata[46:31], in_tdata[30:15]}),
    .pos_i   (pos),
    .acc_o   (acc)
  );

  logic [ENTRY_W-1:0] rdata [NBANK];

  vgs_grid_mem u_mem (
    .clk     (clk),
    .en      (en),
    .acc     (acc),
    .rdata_o (rdata)
  );

  // side info aligned with the bank read data
  logic                      s4_vld_r;
  logic [NBANK-1:0]          s4_bvld_r;
  logic [2:0]                s4_par_r;
  logic [2:0][FRAC_BITS-1:0] s4_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= acc.vld && !acc.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_bvld_r <= acc.bvld;
      s4_par_r  <= acc.par;
      s4_t_r    <= acc.t;
    end
  end

  // corner select: corner k = {dz,dy,dx} sits in bank k ^ parity of the base
  logic signed [VEL_W-1:0] cor_nxt [3*NBANK];
  logic signed [VEL_W-1:0] cor_r [3*NBANK];
  logic                    s5_vld_r;
  logic [FRAC_BITS-1:0]    tx_r, ty_r, tz_r;
  logic [FRAC_BITS-1:0]    ty_d1_r, ty_d2_r;
  logic [FRAC_BITS-1:0]    tz_d1_r, tz_d2_r, tz_d3_r, tz_d4_r;
  logic [ENTRY_W-1:0]      ent;
  logic                    ent_ok;

  always_comb begin
    for (int k = 0; k < NBANK; k++) begin
      ent    = '0;
      ent_ok = 1'b0;
      for (int b = 0; b < NBANK; b++) begin
        if (3'(b) == (3'(k) ^ s4_par_r)) begin
          ent    = rdata[b];
          ent_ok = s4_bvld_r[b];
        end
      end
      ent_ok = ent_ok && !ent[ENTRY_W-1];
      for (int a = 0; a < 3; a++) begin
        cor_nxt[a*NBANK+k] = ent_ok ? $signed(ent[a*VEL_W +: VEL_W]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor_r   <= cor_nxt;
      tx_r    <= s4_t_r[0];
      ty_r    <= s4_t_r[1];
      tz_r    <= s4_t_r[2];
      ty_d1_r <= ty_r;
      ty_d2_r <= ty_d1_r;
      tz_d1_r <= tz_r;
      tz_d2_r <= tz_d1_r;
      tz_d3_r <= tz_d2_r;
      tz_d4_r <= tz_d3_r;
    end
  end

  // x lerps: lane a*4+m blends corners {m,0} and {m,1}
  logic signed [VEL_W-1:0] lx_a [12];
  logic signed [VEL_W-1:0] lx_b [12];
  logic signed [VEL_W-1:0] lx_y [12];
  logic                    lx_vld;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int m = 0; m < 4; m++) begin
        lx_a[a*4+m] = cor_r[a*NBANK + 2*m];
        lx_b[a*4+m] = cor_r[a*NBANK + 2*m + 1];
      end
    end
  end

  vgs_lerp #(.LANES(12)) u_lerp_x (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (s5_vld_r),
    .t_i   (tx_r),
    .a_i   (lx_a),
    .b_i   (lx_b),
    .vld_o (lx_vld),
    .y_o   (lx_y)
  );

  logic signed [VEL_W-1:0] ly_a [6];
  logic signed [VEL_W-1:0] ly_b [6];
  logic signed [VEL_W-1:0] ly_y [6];
  logic                    ly_vld;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int z = 0; z < 2; z++) begin
        ly_a[a*2+z] = lx_y[a*4 + 2*z];
        ly_b[a*2+z] = lx_y[a*4 + 2*z + 1];
      end
    end
  end

  vgs_lerp #(.LANES(6)) u_lerp_y (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (lx_vld),
    .t_i   (ty_d2_r),
    .a_i   (ly_a),
    .b_i   (ly_b),
    .vld_o (ly_vld),
    .y_o   (ly_y)
  );

  logic signed [VEL_W-1:0] lz_a [3];
  logic signed [VEL_W-1:0] lz_b [3];
  logic signed [VEL_W-1:0] lz_y [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lz_a[a] = ly_y[a*2];
      lz_b[a] = ly_y[a*2 + 1];
    end
  end

  vgs_lerp #(.LANES(3)) u_lerp_z (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (ly_vld),
    .t_i   (tz_d4_r),
    .a_i   (lz_a),
    .b_i   (lz_b),
    .vld_o (out_tvalid),
    .y_o   (lz_y)
  );

  assign out_tdata = {lz_y[2], lz_y[1], lz_y[0]};

  a_nearest_no_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (acc.vld && !acc.wr && !cfg_r.mode) |-> (acc.t == '0))
    else $error("nearest sample carries a nonzero blend weight");

  a_nearest_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (acc.vld && !acc.wr && !cfg_r.mode) |-> $onehot0(acc.bvld))
    else $error("nearest sample enables more than one bank");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && acc.vld && acc.wr) |=> !s4_vld_r)
    else $error("cell write produced a sample downstream");

endmodule

>>> test/velocity_grid_sampler_test.sv
module velocity_grid_sampler_test;
  import vgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    vgs_op_t            op;
    logic [14:0]        cell_idx;
    logic signed [15:0] vx, vy, vz;
    logic               solid;
    logic signed [23:0] px, py, pz;
  } grid_item_t;

  typedef struct {
    logic [15:0] vx, vy, vz;
  } vel_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  velocity_grid_sampler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  grid_item_t pending_items[$];
  vel_t       expected_vel[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         stall_req = 0;
  bit         stall_done;
  int         stall_left;
  int         quiet_cycles;

  // grid contents and register copies kept by the predictor
  logic signed [15:0] grid_vel[0:32767][0:2];
  bit                 grid_solid[0:32767];
  bit                 grid_written[0:32767];
  logic               cur_mode;
  logic [15:0]        cur_inv;
  logic [5:0]         cur_ux, cur_uy, cur_uz;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, $signed(exp_v),
             $signed(got_v), $realtime);
    error_count++;
  endtask

  function automatic longint axis_limit(input logic [5:0] n);
    return (n > 32) ? 32 : n;
  endfunction

  function automatic longint cell_component(input longint i, input longint j,
                                            input longint k, input int a);
    int idx;
    if (i < 0 || i >= axis_limit(cur_ux) || j < 0 || j >= axis_limit(cur_uy) ||
        k < 0 || k >= axis_limit(cur_uz))
      return 0;
    idx = int'(i + 32 * (j + 32 * k));
    if (grid_solid[idx])
      return 0;
    return grid_vel[idx][a];
  endfunction

  function automatic longint blend(input longint lo, input longint hi, input longint t);
    return lo + (((hi - lo) * t) >>> FRAC_BITS);
  endfunction

  // grid coordinate with FRAC_BITS fraction, half-cell shift applied in trilinear mode
  function automatic longint grid_coord(input logic signed [23:0] p);
    longint c;
    c = (longint'(p) * longint'(cur_inv)) >>> FRAC_BITS;
    if (cur_mode)
      c -= 1 << (FRAC_BITS - 1);
    return c;
  endfunction

  function automatic vel_t sample_velocity(input grid_item_t it);
    longint c[3], b[3], t[3], r[3];
    longint c00, c10, c01, c11, c0, c1;
    vel_t v;
    c[0] = grid_coord(it.px);
    c[1] = grid_coord(it.py);
    c[2] = grid_coord(it.pz);
    for (int a = 0; a < 3; a++) begin
      b[a] = c[a] >>> FRAC_BITS;
      t[a] = c[a] - (b[a] << FRAC_BITS);
    end
    for (int a = 0; a < 3; a++) begin
      if (!cur_mode) begin
        r[a] = cell_component(b[0], b[1], b[2], a);
      end else begin
        c00 = blend(cell_component(b[0], b[1], b[2], a),
                    cell_component(b[0] + 1, b[1], b[2], a), t[0]);
        c10 = blend(cell_component(b[0], b[1] + 1, b[2], a),
                    cell_component(b[0] + 1, b[1] + 1, b[2], a), t[0]);
        c01 = blend(cell_component(b[0], b[1], b[2] + 1, a),
                    cell_component(b[0] + 1, b[1], b[2] + 1, a), t[0]);
        c11 = blend(cell_component(b[0], b[1] + 1, b[2] + 1, a),
                    cell_component(b[0] + 1, b[1] + 1, b[2] + 1, a), t[0]);
        c0 = blend(c00, c10, t[1]);
        c1 = blend(c01, c11, t[1]);
        r[a] = blend(c0, c1, t[2]);
      end
    end
    v.vx = r[0][15:0];
    v.vy = r[1][15:0];
    v.vz = r[2][15:0];
    return v;
  endfunction

  task automatic queue_write(input int idx, input logic signed [15:0] vx,
                             input logic signed [15:0] vy, input logic signed [15:0] vz,
                             input logic solid);
    grid_item_t it;
    it = '{op: OP_WRITE, cell_idx: idx[14:0], vx: vx, vy: vy, vz: vz, solid: solid,
           px: 24'($urandom), py: 24'($urandom), pz: 24'($urandom)};
    grid_vel[idx][0] = vx;
    grid_vel[idx][1] = vy;
    grid_vel[idx][2] = vz;
    grid_solid[idx]   = solid;
    grid_written[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic queue_random_write(input int idx);
    queue_write(idx, 16'($urandom), 16'($urandom), 16'($urandom), ($urandom_range(3) == 0));
  endtask

  // load every in-range neighbour the sample will touch, then queue the sample
  task automatic queue_sample(input logic signed [23:0] px, input logic signed [23:0] py,
                              input logic signed [23:0] pz);
    grid_item_t it;
    longint bx, by, bz, i, j, k;
    int idx;
    bx = grid_coord(px) >>> FRAC_BITS;
    by = grid_coord(py) >>> FRAC_BITS;
    bz = grid_coord(pz) >>> FRAC_BITS;
    for (int n = 0; n < 8; n++) begin
      i = bx + n[0];
      j = by + n[1];
      k = bz + n[2];
      if (i >= 0 && i < axis_limit(cur_ux) && j >= 0 && j < axis_limit(cur_uy) &&
          k >= 0 && k < axis_limit(cur_uz)) begin
        idx = int'(i + 32 * (j + 32 * k));
        if (!grid_written[idx])
          queue_random_write(idx);
      end
    end
    it = '{op: OP_SAMPLE, cell_idx: 15'($urandom), vx: 16'($urandom), vy: 16'($urandom),
           vz: 16'($urandom), solid: 1'($urandom), px: px, py: py, pz: pz};
    pending_items.push_back(it);
    expected_vel.push_back(sample_velocity(it));
  endtask

  // world position that lands near the used grid, with some margin outside
  function automatic logic signed [23:0] near_grid_pos(input logic [5:0] used);
    longint g, p;
    g = longint'($urandom_range((axis_limit(used) + 4) * 4096)) - 2 * 4096;
    if (cur_inv == 0)
      return 24'($urandom);
    p = (g << FRAC_BITS) / longint'(cur_inv);
    if (p > 8388607)
      p = 8388607;
    if (p < -8388608)
      p = -8388608;
    return p[23:0];
  endfunction

  task automatic write_register(input vgs_cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:   cur_mode = val[0];
      CFG_INV:    cur_inv  = val;
      CFG_X_USED: cur_ux   = val[5:0];
      CFG_Y_USED: cur_uy   = val[5:0];
      CFG_Z_USED: cur_uz   = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic mode, input logic [15:0] inv, input logic [5:0] ux,
                          input logic [5:0] uy, input logic [5:0] uz);
    write_register(CFG_MODE, 16'(mode));
    write_register(CFG_INV, inv);
    write_register(CFG_X_USED, 16'(ux));
    write_register(CFG_Y_USED, 16'(uy));
    write_register(CFG_Z_USED, 16'(uz));
  endtask

  task automatic drain;
    while (pending_items.size() != 0 || expected_vel.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1:    queue_random_write(int'($urandom_range(32767)));
        2:       queue_sample(24'($urandom), 24'($urandom), 24'($urandom));
        default: queue_sample(near_grid_pos(cur_ux), near_grid_pos(cur_uy),
                              near_grid_pos(cur_uz));
      endcase
    end
  endtask

  // sender: the front of pending_items stays in place while it is on the bus;
  // drop it after its transfer, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid && pending_items.size() != 0)
        void'(pending_items.pop_front());
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        grid_item_t it;
        it = pending_items[0];
        in_tvalid <= 1'b1;
        in_tdata  <= {it.pz, it.py, it.px, it.solid, it.vz, it.vy, it.vx, it.cell_idx};
        in_tuser  <= it.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_left <= 300;
      stall_done <= 1'b1;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vel.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        error_count++;
      end else begin
        vel_t e;
        e = expected_vel.pop_front();
        if (out_tdata[15:0] !== e.vx)
          report_mismatch("vel_x", e.vx, out_tdata[15:0]);
        if (out_tdata[31:16] !== e.vy)
          report_mismatch("vel_y", e.vy, out_tdata[31:16]);
        if (out_tdata[47:32] !== e.vz)
          report_mismatch("vel_z", e.vz, out_tdata[47:32]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tdata   = '0;
    in_tuser   = '0;
    cur_mode = 1'b1;
    cur_inv  = 16'd4096;
    cur_ux = 6'd32;
    cur_uy = 6'd32;
    cur_uz = 6'd32;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 32;
    recv_idle_pct = 46;

    // directed: field extremes, solid cells, corners and outside points
    queue_write(0, 16'sh7fff, -16'sd32768, 16'sd0, 1'b0);
    queue_write(1, -16'sd32768, 16'sh7fff, -16'sd1, 1'b0);
    queue_write(32, 16'sd1000, 16'sd2000, -16'sd3000, 1'b1);
    queue_write(32767, -16'sd1, -16'sd1, -16'sd1, 1'b1);
    queue_write(32767, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    queue_sample(24'sd0, 24'sd0, 24'sd0);
    queue_sample(24'sd2048, 24'sd2048, 24'sd2048);
    queue_sample(24'sd6144, 24'sd2048, 24'sd2048);
    queue_sample(24'sd4095, 24'sd4095, 24'sd4095);
    queue_sample(-24'sd1, 24'sd0, 24'sd0);
    queue_sample(24'sd131071, 24'sd131071, 24'sd131071);
    queue_sample(24'sd131072, 24'sd0, 24'sd0);
    queue_sample(-24'sd8388608, -24'sd8388608, -24'sd8388608);
    queue_sample(24'sd8388607, 24'sd8388607, 24'sd8388607);
    queue_sample(24'sd129024, 24'sd129024, 24'sd129024);
    drain();

    set_grid(1'b0, 16'd4096, 6'd32, 6'd32, 6'd32);
    queue_sample(24'sd0, 24'sd0, 24'sd0);
    queue_sample(24'sd4096, 24'sd0, 24'sd0);
    queue_sample(24'sd0, 24'sd4096, 24'sd0);
    queue_sample(-24'sd1, 24'sd0, 24'sd0);
    queue_sample(24'sd131071, 24'sd131071, 24'sd131071);
    random_phase(40);
    drain();

    set_grid(1'b1, 16'd65535, 6'd1, 6'd1, 6'd1);
    random_phase(60);
    drain();

    // zero used count on one axis and a count past the grid on another
    set_grid(1'b1, 16'd1, 6'd63, 6'd0, 6'd32);
    random_phase(40);
    drain();

    send_idle_pct = 46;
    recv_idle_pct = 32;
    set_grid(1'b0, 16'd8192, 6'd17, 6'd5, 6'd32);
    random_phase(40);
    drain();

    set_grid(1'b1, 16'd2731, 6'd32, 6'd32, 6'd32);
    stall_req = 1'b1;
    random_phase(60);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(1'b1, 16'd0, 6'd32, 6'd32, 6'd32);
    random_phase(20);
    drain();

    set_grid(1'b1, 16'd4096, 6'd33, 6'd31, 6'd63);
    random_phase(35);
    drain();

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> sim.f
design/vgs_pkg.sv
design/vgs_coord.sv
design/vgs_grid_mem.sv
design/vgs_lerp.sv
design/velocity_grid_sampler.sv
test/velocity_grid_sampler_test.sv
